/* src/rci_pkg.sv */
package rci_pkg;

  localparam int WORD_W  = 32;
  localparam int IDX_W   = 8;
  localparam int BANK_W  = 7;
  localparam int SMP_W   = 16;
  localparam int WGT_W   = 10;
  localparam int SQ_W    = 2 * WGT_W;
  localparam int CUBE_W  = 28;
  localparam int PROD_W  = WORD_W + WGT_W;
  localparam int LIN_W   = PROD_W + 1;
  localparam int CPROD_W = CUBE_W + WORD_W;
  localparam int WIDE_W  = 64;

  localparam logic [1:0] ACT_LOAD_KNOT = 2'd0;
  localparam logic [1:0] ACT_LOAD_CURV = 2'd1;
  localparam logic [1:0] ACT_EVAL      = 2'd2;

  localparam logic [SMP_W-1:0] KNOT_OFFSET = 16'd127;
  localparam logic [IDX_W-1:0] SEG_LAST    = 8'd254;
  localparam logic signed [WGT_W-1:0] WGT_ONE = 10'sd256;

  typedef struct packed {
    logic valid;
    logic mode;
  } stage_ctl_t;

endpackage

/* src/rci_table.sv */
module rci_table (
  input  logic                              clk,
  input  logic                              we,
  input  logic [rci_pkg::IDX_W-1:0]         waddr,
  input  logic signed [rci_pkg::WORD_W-1:0] wdata,
  input  logic [rci_pkg::IDX_W-1:0]         seg,
  output logic signed [rci_pkg::WORD_W-1:0] y_lo,
  output logic signed [rci_pkg::WORD_W-1:0] y_hi
);
  import rci_pkg::*;

  // even/odd banks: knots seg and seg+1 always sit in different banks
  logic signed [WORD_W-1:0] even_mem [2**BANK_W];
  logic signed [WORD_W-1:0] odd_mem  [2**BANK_W];
  logic signed [WORD_W-1:0] even_q;
  logic signed [WORD_W-1:0] odd_q;
  logic                     swap;
  logic [BANK_W-1:0]        even_addr;
  logic [BANK_W-1:0]        odd_addr;

  assign odd_addr  = seg[IDX_W-1:1];
  assign even_addr = seg[IDX_W-1:1] + BANK_W'(seg[0]);

  always_ff @(posedge clk) begin
    if (we && !waddr[0]) begin
      even_mem[waddr[IDX_W-1:1]] <= wdata;
    end
    even_q <= even_mem[even_addr];
  end

  always_ff @(posedge clk) begin
    if (we && waddr[0]) begin
      odd_mem[waddr[IDX_W-1:1]] <= wdata;
    end
    odd_q <= odd_mem[odd_addr];
  end

  always_ff @(posedge clk) begin
    swap <= seg[0];
  end

  assign y_lo = swap ? odd_q : even_q;
  assign y_hi = swap ? even_q : odd_q;

endmodule

/* src/rci_arith.sv */
module rci_arith (
  input  logic                               clk,
  input  logic                               rst,
  input  rci_pkg::stage_ctl_t                in_ctl,
  input  logic signed [rci_pkg::WGT_W-1:0]   wa_in,
  input  logic signed [rci_pkg::WGT_W-1:0]   wb_in,
  input  logic signed [rci_pkg::WORD_W-1:0]  yl,
  input  logic signed [rci_pkg::WORD_W-1:0]  yh,
  input  logic signed [rci_pkg::WORD_W-1:0]  cl,
  input  logic signed [rci_pkg::WORD_W-1:0]  ch,
  output rci_pkg::stage_ctl_t                out_ctl,
  output logic signed [rci_pkg::WIDE_W-1:0]  result
);
  import rci_pkg::*;

  localparam logic signed [WIDE_W-1:0] RND_LIN = 64'sd128;
  localparam logic signed [WIDE_W-1:0] RND_SPL = 64'sd8388608;

  // stage 2: knot products and squares
  stage_ctl_t                s2_ctl;
  logic signed [PROD_W-1:0]  s2_pa;
  logic signed [PROD_W-1:0]  s2_pb;
  logic signed [SQ_W-1:0]    s2_a2;
  logic signed [SQ_W-1:0]    s2_b2;
  logic signed [WGT_W-1:0]   s2_a;
  logic signed [WGT_W-1:0]   s2_b;
  logic signed [WORD_W-1:0]  s2_cl;
  logic signed [WORD_W-1:0]  s2_ch;

  // stage 3: linear sum and cubic weights
  stage_ctl_t                s3_ctl;
  logic signed [LIN_W-1:0]   s3_lin;
  logic signed [CUBE_W-1:0]  s3_wa;
  logic signed [CUBE_W-1:0]  s3_wb;
  logic signed [WORD_W-1:0]  s3_cl;
  logic signed [WORD_W-1:0]  s3_ch;

  // stage 4: curvature products
  stage_ctl_t                s4_ctl;
  logic signed [LIN_W-1:0]   s4_lin;
  logic signed [CPROD_W-1:0] s4_ca;
  logic signed [CPROD_W-1:0] s4_cb;

  logic signed [SQ_W+WGT_W-1:0] a3;
  logic signed [SQ_W+WGT_W-1:0] b3;
  logic signed [SQ_W+WGT_W-1:0] wa_full;
  logic signed [SQ_W+WGT_W-1:0] wb_full;
  logic signed [WIDE_W-1:0]     lin_x;
  logic signed [WIDE_W-1:0]     spl_sum;
  logic signed [WIDE_W-1:0]     r_lin;
  logic signed [WIDE_W-1:0]     r_spl;

  always_ff @(posedge clk) begin
    s2_pa <= yl * wa_in;
    s2_pb <= yh * wb_in;
    s2_a2 <= wa_in * wa_in;
    s2_b2 <= wb_in * wb_in;
    s2_a  <= wa_in;
    s2_b  <= wb_in;
    s2_cl <= cl;
    s2_ch <= ch;
  end

  assign a3      = s2_a2 * s2_a;
  assign b3      = s2_b2 * s2_b;
  assign wa_full = a3 - ((SQ_W+WGT_W)'(s2_a) <<< 16);
  assign wb_full = b3 - ((SQ_W+WGT_W)'(s2_b) <<< 16);

  always_ff @(posedge clk) begin
    s3_lin <= LIN_W'(s2_pa) + LIN_W'(s2_pb);
    s3_wa  <= wa_full[CUBE_W-1:0];
    s3_wb  <= wb_full[CUBE_W-1:0];
    s3_cl  <= s2_cl;
    s3_ch  <= s2_ch;
  end

  always_ff @(posedge clk) begin
    s4_lin <= s3_lin;
    s4_ca  <= s3_wa * s3_cl;
    s4_cb  <= s3_wb * s3_ch;
  end

  assign lin_x   = WIDE_W'(s4_lin);
  assign spl_sum = (lin_x <<< 16) + WIDE_W'(s4_ca) + WIDE_W'(s4_cb) + RND_SPL;
  assign r_lin   = (lin_x + RND_LIN) >>> 8;
  assign r_spl   = spl_sum >>> 24;

  always_ff @(posedge clk) begin
    result <= s4_ctl.mode ? r_spl : r_lin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl  <= '0;
      s3_ctl  <= '0;
      s4_ctl  <= '0;
      out_ctl <= '0;
    end else begin
      s2_ctl  <= in_ctl;
      s3_ctl  <= s2_ctl;
      s4_ctl  <= s3_ctl;
      out_ctl <= s4_ctl;
    end
  end

endmodule

/* src/response_curve_interpolator.sv */
// An evaluation transfer reaches its result transfer through s1_ctl, s2_ctl, s3_ctl, s4_ctl, out_ctl and done.
// Throughput: one transfer per cycle, loads and evaluations alike; busy stays low.
// Both tables are even/odd banked so the two neighbor knots read in the same cycle.
// Reset clears interp_mode and the pipeline valid bits; table contents stay
// undefined until loaded. The receiver cannot stall, so the pipeline never holds.
module response_curve_interpolator #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        action,
  input  logic [rci_pkg::IDX_W-1:0]         knot_index,
  input  logic signed [rci_pkg::WORD_W-1:0] table_word,
  input  logic [rci_pkg::SMP_W-1:0]         sample,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  output logic                              done,
  output logic signed [rci_pkg::WORD_W-1:0] curve_value,
  output logic                              saturated
);
  import rci_pkg::*;

  localparam logic signed [WIDE_W-1:0] VMAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [WIDE_W-1:0] VMIN = -VMAX - 64'sd1;

  logic                     interp_mode;
  logic                     xfer;
  logic                     eval_xfer;
  logic [IDX_W-1:0]         seg;
  logic [SMP_W-1:0]         seg_raw;
  logic [SMP_W:0]           delta;
  logic signed [WGT_W-1:0]  wb_next;
  logic signed [WGT_W-1:0]  wa_next;
  logic signed [WGT_W-1:0]  s1_wa;
  logic signed [WGT_W-1:0]  s1_wb;
  stage_ctl_t               s1_ctl;
  stage_ctl_t               arith_ctl;
  logic signed [WORD_W-1:0] yl;
  logic signed [WORD_W-1:0] yh;
  logic signed [WORD_W-1:0] cl;
  logic signed [WORD_W-1:0] ch;
  logic signed [WIDE_W-1:0] r;
  logic signed [WIDE_W-1:0] r_clip;
  logic                     r_sat;

  assign busy      = 1'b0;
  assign xfer      = start && !busy;
  assign eval_xfer = xfer && (action == ACT_EVAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode <= 1'b0;
    end else if (cfg_we) begin
      interp_mode <= cfg_wdata;
    end
  end

  // segment select with end clamps
  assign seg_raw = (sample - KNOT_OFFSET) >> 8;
  always_comb begin
    if (sample < KNOT_OFFSET) begin
      seg = '0;
    end else if (seg_raw[IDX_W-1:0] > SEG_LAST) begin
      seg = SEG_LAST;
    end else begin
      seg = seg_raw[IDX_W-1:0];
    end
  end

  assign delta   = {1'b0, sample} - {1'b0, seg, 8'd0} - (SMP_W+1)'(KNOT_OFFSET);
  assign wb_next = delta[WGT_W-1:0];
  assign wa_next = WGT_ONE - wb_next;

  always_ff @(posedge clk) begin
    s1_wa <= wa_next;
    s1_wb <= wb_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl.valid <= eval_xfer;
      s1_ctl.mode  <= interp_mode;
    end
  end

  rci_table u_knots (
    .clk   (clk),
    .we    (xfer && (action == ACT_LOAD_KNOT)),
    .waddr (knot_index),
    .wdata (table_word),
    .seg   (seg),
    .y_lo  (yl),
    .y_hi  (yh)
  );

  rci_table u_curv (
    .clk   (clk),
    .we    (xfer && (action == ACT_LOAD_CURV)),
    .waddr (knot_index),
    .wdata (table_word),
    .seg   (seg),
    .y_lo  (cl),
    .y_hi  (ch)
  );

  rci_arith u_arith (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (s1_ctl),
    .wa_in   (s1_wa),
    .wb_in   (s1_wb),
    .yl      (yl),
    .yh      (yh),
    .cl      (cl),
    .ch      (ch),
    .out_ctl (arith_ctl),
    .result  (r)
  );

  always_comb begin
    if (r > VMAX) begin
      r_clip = VMAX;
      r_sat  = 1'b1;
    end else if (r < VMIN) begin
      r_clip = VMIN;
      r_sat  = 1'b1;
    end else begin
      r_clip = r;
      r_sat  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    curve_value <= r_clip[WORD_W-1:0];
    saturated   <= r_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= arith_ctl.valid;
    end
  end

  a_done_follows_eval: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(eval_xfer, 6))
    else $error("result without a matching evaluation transfer");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |->
      (curve_value == VMAX[WORD_W-1:0] || curve_value == VMIN[WORD_W-1:0]))
    else $error("saturated result not at a range limit");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (xfer && action != ACT_EVAL) |-> ##6 !done)
    else $error("load transfer produced a result");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import rci_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     sat;
  } curve_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               action;
  logic [IDX_W-1:0]         knot_index;
  logic signed [WORD_W-1:0] table_word;
  logic [SMP_W-1:0]         sample;
  logic                     cfg_we;
  logic                     cfg_wdata;
  logic                     done;
  logic signed [WORD_W-1:0] curve_value;
  logic                     saturated;

  logic signed [WORD_W-1:0] knot_mirror [256];
  logic signed [WORD_W-1:0] curv_mirror [256];
  logic                     mode_shadow;
  curve_t                   pending_curve [$];
  curve_t                   head_curve;
  int                       mismatch_count;
  int                       cycles;
  logic                     no_gaps;

  response_curve_interpolator u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .knot_index  (knot_index),
    .table_word  (table_word),
    .sample      (sample),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .done        (done),
    .curve_value (curve_value),
    .saturated   (saturated)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic curve_t interp_curve(input logic [SMP_W-1:0] z);
    longint zz, seg, dist_z, wa, yl, yh, cl, ch, acc, r;
    curve_t res;
    zz = longint'(z);
    if (zz < longint'(KNOT_OFFSET)) begin
      seg = 0;
    end else begin
      seg = (zz - longint'(KNOT_OFFSET)) >>> 8;
      if (seg > longint'(SEG_LAST)) seg = longint'(SEG_LAST);
    end
    dist_z = zz - (seg * 256 + longint'(KNOT_OFFSET));
    wa     = 256 - dist_z;
    yl     = longint'(knot_mirror[seg[IDX_W-1:0]]);
    yh     = longint'(knot_mirror[IDX_W'(seg + 1)]);
    if (!mode_shadow) begin
      r = (wa * yl + dist_z * yh + 128) >>> 8;
    end else begin
      cl  = longint'(curv_mirror[seg[IDX_W-1:0]]);
      ch  = longint'(curv_mirror[IDX_W'(seg + 1)]);
      acc = (wa * yl + dist_z * yh) * 65536;
      acc = acc + (wa * wa * wa - 65536 * wa) * cl;
      acc = acc + (dist_z * dist_z * dist_z - 65536 * dist_z) * ch;
      r   = (acc + (longint'(1) <<< 23)) >>> 24;
    end
    res.sat = 1'b0;
    if (r > 64'sh7FFFFFFF) begin
      r = 64'sh7FFFFFFF;
      res.sat = 1'b1;
    end else if (r < -64'sh80000000) begin
      r = -64'sh80000000;
      res.sat = 1'b1;
    end
    res.value = r[WORD_W-1:0];
    return res;
  endfunction

  function automatic logic signed [WORD_W-1:0] rand_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom;
    if (sel == 1) return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    return int'($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
  endfunction

  function automatic logic [SMP_W-1:0] rand_sample();
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) return SMP_W'($urandom_range(0, 126));
      return SMP_W'($urandom_range(65409, 65535));
    end
    return SMP_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [IDX_W-1:0] idx,
                           input logic signed [WORD_W-1:0] word,
                           input logic [SMP_W-1:0] smp);
    @(negedge clk);
    while (!no_gaps && $urandom_range(0, 99) < 23) begin
      start  <= 1'b0;
      action <= 2'($urandom);
      sample <= SMP_W'($urandom);
      @(negedge clk);
    end
    start      <= 1'b1;
    action     <= act;
    knot_index <= idx;
    table_word <= word;
    sample     <= smp;
    do @(posedge clk); while (busy);
    case (act)
      ACT_LOAD_KNOT: knot_mirror[idx] = word;
      ACT_LOAD_CURV: curv_mirror[idx] = word;
      ACT_EVAL:      pending_curve.push_back(interp_curve(smp));
      default: ;
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_curve.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= ~m;
    mode_shadow = m;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_curve.size() == 0) begin
        $display("%0t: unexpected result curve_value=%h saturated=%b",
                 $time, curve_value, saturated);
        mismatch_count++;
      end else begin
        head_curve = pending_curve.pop_front();
        if (curve_value !== head_curve.value) begin
          $display("%0t: curve_value expected %h got %h", $time, head_curve.value,
                   curve_value);
          mismatch_count++;
        end
        if (saturated !== head_curve.sat) begin
          $display("%0t: saturated expected %b got %b", $time, head_curve.sat,
                   saturated);
          mismatch_count++;
        end
      end
    end
  end

  // every entry loaded before any evaluation can read it
  task automatic test_fill_tables();
    for (int i = 0; i < 256; i++)
      send_item(ACT_LOAD_KNOT, IDX_W'(i), rand_word(), SMP_W'($urandom));
    for (int i = 0; i < 256; i++)
      send_item(ACT_LOAD_CURV, IDX_W'(i), rand_word(), SMP_W'($urandom));
  endtask

  task automatic test_end_segments();
    write_mode(1'b0);
    send_item(ACT_LOAD_KNOT, 8'd0,   32'sh7FFFFFFF, 16'hFFFF);
    send_item(ACT_LOAD_KNOT, 8'd1,   32'sh80000000, 16'h0000);
    send_item(ACT_LOAD_KNOT, 8'd254, 32'sh80000000, 16'hFFFF);
    send_item(ACT_LOAD_KNOT, 8'd255, 32'sh7FFFFFFF, 16'h0000);
    send_item(ACT_LOAD_CURV, 8'd0,   32'sh7FFFFFFF, 16'h0000);
    send_item(ACT_LOAD_CURV, 8'd1,   32'sh80000000, 16'hFFFF);
    send_item(ACT_LOAD_CURV, 8'd254, 32'sh80000000, 16'h0000);
    send_item(ACT_LOAD_CURV, 8'd255, 32'sh7FFFFFFF, 16'hFFFF);
    send_item(ACT_EVAL, 8'hFF, 32'sh7FFFFFFF, 16'd0);
    send_item(ACT_EVAL, 8'h00, 32'sh80000000, 16'd127);
    send_item(ACT_EVAL, 8'hFF, 32'sh00000000, 16'd383);
    send_item(ACT_EVAL, 8'h00, 32'shFFFFFFFF, 16'd65535);
    // unused code: no result, no table change
    send_item(ACT_UNUSED, 8'hFF, 32'shFFFFFFFF, 16'hFFFF);
    write_mode(1'b1);
    send_item(ACT_EVAL, 8'h00, 32'sh0, 16'd0);
    send_item(ACT_EVAL, 8'h00, 32'sh0, 16'd126);
    send_item(ACT_EVAL, 8'h00, 32'sh0, 16'd128);
    send_item(ACT_EVAL, 8'h00, 32'sh0, 16'd384);
    send_item(ACT_EVAL, 8'h00, 32'sh0, 16'd32767);
    send_item(ACT_EVAL, 8'h00, 32'sh0, 16'd65408);
    send_item(ACT_EVAL, 8'h00, 32'sh0, 16'd65409);
    send_item(ACT_EVAL, 8'h00, 32'sh0, 16'd65535);
  endtask

  task automatic test_random_traffic(input logic m, input int n_items, input logic steady);
    int kind;
    int sent;
    write_mode(m);
    no_gaps = steady;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        send_item(ACT_UNUSED, IDX_W'($urandom), $urandom, SMP_W'($urandom));
      end else begin
        if (kind < 25)
          send_item(ACT_LOAD_KNOT, IDX_W'($urandom), rand_word(), SMP_W'($urandom));
        else if (kind < 40)
          send_item(ACT_LOAD_CURV, IDX_W'($urandom), rand_word(), SMP_W'($urandom));
        else send_item(ACT_EVAL, IDX_W'($urandom), $urandom, rand_sample());
        sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    start          = 1'b0;
    action         = ACT_LOAD_KNOT;
    knot_index     = '0;
    table_word     = '0;
    sample         = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    mode_shadow    = 1'b0;
    mismatch_count = 0;
    cycles         = 0;
    no_gaps        = 1'b0;
    for (int i = 0; i < 256; i++) begin
      knot_mirror[IDX_W'(i)] = '0;
      curv_mirror[IDX_W'(i)] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_fill_tables();
    test_end_segments();
    test_random_traffic(1'b1, 130, 1'b0);
    test_random_traffic(1'b0, 130, 1'b0);
    test_random_traffic(1'b1, 120, 1'b1);
    test_random_traffic(1'b0, 120, 1'b0);
    drain();

    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
